### hdl/text_tile_cursor_writer_top_assert.svh
// Assertion macros shared by the text tile cursor writer modules.
`ifndef TEXT_TILE_CURSOR_WRITER_TOP_ASSERT_SVH
`define TEXT_TILE_CURSOR_WRITER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as pre.
`define TTCW_ASSERT_NOW(label, pre, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (cons)) \
    else $error("text tile cursor writer check failed");

// Check that cons holds in the cycle after pre.
`define TTCW_ASSERT_NEXT(label, pre, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (cons)) \
    else $error("text tile cursor writer check failed");

`endif

### hdl/ttcw_pkg.sv
// Types, constants and the glyph map of the text tile cursor writer.
package ttcw_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_COLUMN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_ROW      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_INDEX = 2'd3;

  // Rotation codes; the unused code behaves as no rotation
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_CCW  = 2'd2;

  localparam logic [1:0] ROTATION_RESET = ROT_NONE;
  localparam logic [5:0] LAST_COLUMN_RESET = 6'd31;
  localparam logic [5:0] LAST_ROW_RESET = 6'd23;
  localparam logic [3:0] PALETTE_RESET = 4'd0;

  // Glyph map constants
  localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
  localparam logic [7:0] STAR_BYTE     = 8'd42;
  localparam logic [7:0] FIRST_PRINT   = 8'd32;
  localparam logic [7:0] NEWLINE_GLYPH = 8'd200;
  localparam logic [7:0] ACCENT_BASE   = 8'd96;
  localparam int ACCENT_COUNT = 18;

  localparam logic [7:0] ACCENT_BYTES [ACCENT_COUNT] = '{
    8'd199, 8'd231, 8'd209, 8'd241, 8'd193, 8'd201, 8'd205, 8'd211, 8'd218,
    8'd225, 8'd233, 8'd237, 8'd243, 8'd250, 8'd239, 8'd252, 8'd161, 8'd191
  };

  // Per-item request to the cursor
  typedef struct packed {
    logic       sos;
    logic [5:0] start_col;
    logic [5:0] start_row;
    logic       wr;
    logic       nl;
  } cursor_cmd_t;

  // Position the current item is written at
  typedef struct packed {
    logic [5:0] col;
    logic [5:0] row;
  } cursor_pos_t;

  // Map a Latin-1 byte to its glyph code; newline gets a code of its own
  function automatic logic [7:0] glyph_of(input logic [7:0] b);
    logic [7:0] g;
    g = 8'd0;
    if (b == NEWLINE_BYTE) begin
      g = NEWLINE_GLYPH;
    end else if (b < FIRST_PRINT || b == STAR_BYTE) begin
      g = 8'd0;
    end else if (!b[7]) begin
      g = b - FIRST_PRINT;
    end else begin
      for (int i = 0; i < ACCENT_COUNT; i++) begin
        if (ACCENT_BYTES[i] == b) g = ACCENT_BASE + 8'(i);
      end
    end
    return g;
  endfunction

endpackage

### hdl/ttcw_if.sv
// Valid/ready channels for character items and tile write items.
interface ttcw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       start_of_string;
  logic [5:0] start_col;
  logic [5:0] start_row;
  logic       screen_sel;
  logic [1:0] layer_sel;

  modport source (output valid, char_byte, start_of_string, start_col, start_row,
                  screen_sel, layer_sel, input ready);
  modport sink (input valid, char_byte, start_of_string, start_col, start_row,
                screen_sel, layer_sel, output ready);
endinterface

interface ttcw_tile_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [5:0]  tile_col;
  logic [5:0]  tile_row;
  logic [15:0] tile_value;
  logic        out_screen;
  logic [1:0]  out_layer;

  modport source (output valid, write_valid, tile_col, tile_row, tile_value,
                  out_screen, out_layer, input ready);
  modport sink (input valid, write_valid, tile_col, tile_row, tile_value,
                out_screen, out_layer, output ready);
endinterface

### hdl/ttcw_cursor.sv
// Text cursor: start load with rotation, clamping and advance with wrap.
`include "text_tile_cursor_writer_top_assert.svh"

module ttcw_cursor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  ttcw_pkg::cursor_cmd_t cmd,
  input  logic [1:0]            rot,
  input  logic [5:0]            lc,
  input  logic [5:0]            lr,
  output ttcw_pkg::cursor_pos_t pos
);

  logic [5:0] col;
  logic [5:0] row;
  logic [5:0] col_next;
  logic [5:0] row_next;
  logic [5:0] base_col;
  logic [5:0] base_row;
  logic [5:0] cur_col;
  logic [5:0] cur_row;
  logic       eol;
  logic       wrap;

  // Pick the start position for the rotation, or the held cursor
  always_comb begin
    base_col = col;
    base_row = row;
    if (cmd.sos) begin
      case (rot)
        ttcw_pkg::ROT_CW: begin
          base_col = (cmd.start_row > lc) ? 6'd0 : lc - cmd.start_row;
          base_row = (cmd.start_col > lr) ? lr : cmd.start_col;
        end
        ttcw_pkg::ROT_CCW: begin
          base_col = (cmd.start_row > lc) ? lc : cmd.start_row;
          base_row = (cmd.start_col > lr) ? 6'd0 : lr - cmd.start_col;
        end
        default: begin
          base_col = (cmd.start_col > lc) ? lc : cmd.start_col;
          base_row = (cmd.start_row > lr) ? lr : cmd.start_row;
        end
      endcase
    end
  end

  // Clamp to the current map limits
  assign cur_col = (base_col > lc) ? lc : base_col;
  assign cur_row = (base_row > lr) ? lr : base_row;
  assign pos.col = cur_col;
  assign pos.row = cur_row;

  // Advance along the line, wrap to the next line on end of line or newline
  always_comb begin
    eol      = 1'b0;
    col_next = cur_col;
    row_next = cur_row;
    case (rot)
      ttcw_pkg::ROT_CW: begin
        eol  = cmd.wr && (cur_row == lr);
        wrap = eol || cmd.nl;
        if (wrap) begin
          row_next = 6'd0;
          col_next = (cur_col == 6'd0) ? lc : cur_col - 6'd1;
        end else if (cmd.wr) begin
          row_next = cur_row + 6'd1;
        end
      end
      ttcw_pkg::ROT_CCW: begin
        eol  = cmd.wr && (cur_row == 6'd0);
        wrap = eol || cmd.nl;
        if (wrap) begin
          row_next = lr;
          col_next = (cur_col == lc) ? 6'd0 : cur_col + 6'd1;
        end else if (cmd.wr) begin
          row_next = cur_row - 6'd1;
        end
      end
      default: begin
        eol  = cmd.wr && (cur_col == lc);
        wrap = eol || cmd.nl;
        if (wrap) begin
          col_next = 6'd0;
          row_next = (cur_row == lr) ? 6'd0 : cur_row + 6'd1;
        end else if (cmd.wr) begin
          col_next = cur_col + 6'd1;
        end
      end
    endcase
  end

  // Hold the cursor between items
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= 6'd0;
      row <= 6'd0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
    end
  end

  `TTCW_ASSERT_NEXT(a_col_in_map, step, col <= $past(lc))
  `TTCW_ASSERT_NEXT(a_row_in_map, step, row <= $past(lr))
  `TTCW_ASSERT_NEXT(a_hold_when_idle, !step, col == $past(col) && row == $past(row))

endmodule

### hdl/text_tile_cursor_writer_top.sv
// Text tile cursor writer: turns character items into tile-map write items.
//
// Each accepted character item produces exactly one result item: the item
// enters the input register at the accepting edge, and its result enters the
// result register once that register is free or being read. One item is
// taken every cycle when the result side keeps up. The rate is set by the
// cursor register: its next value (start load, clamp, advance with wrap) is
// worked out combinationally from the item held in the input register. While
// the result register holds an unread result, the input register still takes
// one more item. Configuration writes take effect on the next clock edge.
`include "text_tile_cursor_writer_top_assert.svh"

module text_tile_cursor_writer_top #(
  parameter int LAST_GLYPH_CODE = 113,
  parameter int MAP_SIDE_TILES  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  ttcw_char_if.sink                           char_in,
  ttcw_tile_if.source                         tile_out,
  input  logic                                cfg_write,
  input  logic [ttcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ttcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [6:0] MAP_LAST  = 7'(MAP_SIDE_TILES - 1);
  localparam logic [7:0] GLYPH_MAX = 8'(LAST_GLYPH_CODE);

  // Configuration registers
  logic [1:0] rotation_mode;
  logic [5:0] last_column;
  logic [5:0] last_row;
  logic [3:0] palette_index;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sos;
  logic [5:0] s1_start_col;
  logic [5:0] s1_start_row;
  logic       s1_screen;
  logic [1:0] s1_layer;

  // Result register
  logic        out_valid;
  logic        out_write;
  logic [5:0]  out_col;
  logic [5:0]  out_row;
  logic [15:0] out_value;
  logic        out_screen;
  logic [1:0]  out_layer;

  logic                  advance;
  logic [5:0]            lc;
  logic [5:0]            lr;
  logic [7:0]            glyph;
  logic                  wr;
  logic                  out_blank;
  ttcw_pkg::cursor_cmd_t cmd;
  ttcw_pkg::cursor_pos_t pos;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode <= ttcw_pkg::ROTATION_RESET;
      last_column   <= ttcw_pkg::LAST_COLUMN_RESET;
      last_row      <= ttcw_pkg::LAST_ROW_RESET;
      palette_index <= ttcw_pkg::PALETTE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ttcw_pkg::REG_ROTATION_MODE: rotation_mode <= cfg_data[1:0];
        ttcw_pkg::REG_LAST_COLUMN:   last_column   <= cfg_data[5:0];
        ttcw_pkg::REG_LAST_ROW:      last_row      <= cfg_data[5:0];
        ttcw_pkg::REG_PALETTE_INDEX: palette_index <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Limit the layer size to the map
  assign lc = ({1'b0, last_column} > MAP_LAST) ? MAP_LAST[5:0] : last_column;
  assign lr = ({1'b0, last_row} > MAP_LAST) ? MAP_LAST[5:0] : last_row;

  // Move an item on when the result register is free or being read
  assign advance       = s1_valid && (!out_valid || tile_out.ready);
  assign char_in.ready = !s1_valid || advance;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      s1_byte      <= char_in.char_byte;
      s1_sos       <= char_in.start_of_string;
      s1_start_col <= char_in.start_col;
      s1_start_row <= char_in.start_row;
      s1_screen    <= char_in.screen_sel;
      s1_layer     <= char_in.layer_sel;
    end
  end

  // Map the byte to a glyph
  assign glyph = ttcw_pkg::glyph_of(s1_byte);
  assign wr    = (glyph <= GLYPH_MAX);

  assign cmd.sos       = s1_sos;
  assign cmd.start_col = s1_start_col;
  assign cmd.start_row = s1_start_row;
  assign cmd.wr        = wr;
  assign cmd.nl        = (glyph == ttcw_pkg::NEWLINE_GLYPH);

  ttcw_cursor u_cursor (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd),
    .rot  (rotation_mode),
    .lc   (lc),
    .lr   (lr),
    .pos  (pos)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tile_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_write  <= wr;
      out_col    <= wr ? pos.col : 6'd0;
      out_row    <= wr ? pos.row : 6'd0;
      out_value  <= wr ? {palette_index, 4'd0, glyph} : 16'd0;
      out_screen <= wr ? s1_screen : 1'b0;
      out_layer  <= wr ? s1_layer : 2'd0;
    end
  end

  assign tile_out.valid       = out_valid;
  assign tile_out.write_valid = out_write;
  assign tile_out.tile_col    = out_col;
  assign tile_out.tile_row    = out_row;
  assign tile_out.tile_value  = out_value;
  assign tile_out.out_screen  = out_screen;
  assign tile_out.out_layer   = out_layer;

  // Blank result fields
  assign out_blank = (out_value == 16'd0) && (out_col == 6'd0) && (out_row == 6'd0);

  `TTCW_ASSERT_NEXT(a_stage_drains, s1_valid && !out_valid, out_valid)
  `TTCW_ASSERT_NOW(a_no_write_is_zero, out_valid && !out_write, out_blank)
  `TTCW_ASSERT_NEXT(a_result_held, out_valid && !tile_out.ready, out_valid && $stable(out_value))

endmodule

### tb/tb_top.sv
// Self-checking testbench for the text tile cursor writer: random idling on both channels.
module tb_top;

  localparam int GLYPH_LIMIT = 113;
  localparam int MAP_TILES = 64;
  localparam logic [1:0] ROT_UNUSED = 2'd3;
  localparam logic [7:0] LATIN1_ACCENTS [18] = '{
    8'd199, 8'd231, 8'd209, 8'd241, 8'd193, 8'd201, 8'd205, 8'd211, 8'd218,
    8'd225, 8'd233, 8'd237, 8'd243, 8'd250, 8'd239, 8'd252, 8'd161, 8'd191
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       sos;
    logic [5:0] start_col;
    logic [5:0] start_row;
    logic       screen;
    logic [1:0] layer;
  } char_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [15:0] value;
    logic        screen;
    logic [1:0]  layer;
  } tile_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [ttcw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ttcw_pkg::CFG_DATA_W-1:0] cfg_data;

  ttcw_char_if char_ch ();
  ttcw_tile_if tile_ch ();

  text_tile_cursor_writer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .tile_out (tile_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow configuration and cursor
  logic [1:0] shadow_rotation = ttcw_pkg::ROT_NONE;
  logic [5:0] shadow_last_col = ttcw_pkg::LAST_COLUMN_RESET;
  logic [5:0] shadow_last_row = ttcw_pkg::LAST_ROW_RESET;
  logic [3:0] shadow_palette = ttcw_pkg::PALETTE_RESET;
  int cursor_col = 0;
  int cursor_row = 0;

  char_item_t char_pending_q[$];
  tile_write_t tile_expect_q[$];
  char_item_t char_now;
  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int tiles_written = 0;
  int blank_results = 0;
  int phase_count = 0;

  // Map a byte to its glyph code; newline gets a code above the glyph range
  function automatic int glyph_code(logic [7:0] b);
    int g;
    int i;
    g = 0;
    if (b == ttcw_pkg::NEWLINE_BYTE) begin
      g = int'(ttcw_pkg::NEWLINE_GLYPH);
    end else if (b < ttcw_pkg::FIRST_PRINT || b == ttcw_pkg::STAR_BYTE) begin
      g = 0;
    end else if (b < 8'd128) begin
      g = int'(b) - int'(ttcw_pkg::FIRST_PRINT);
    end else begin
      for (i = 0; i < 18; i++) begin
        if (LATIN1_ACCENTS[i] == b) g = 96 + i;
      end
    end
    return g;
  endfunction

  // Work out the tile write of one character and advance the shadow cursor
  function automatic tile_write_t render_char(char_item_t c);
    tile_write_t w;
    int lc;
    int lr;
    int g;
    int sc;
    int sr;
    logic [1:0] rot;
    bit put;
    bit nl;
    bit eol;
    lc = (int'(shadow_last_col) < MAP_TILES - 1) ? int'(shadow_last_col) : MAP_TILES - 1;
    lr = (int'(shadow_last_row) < MAP_TILES - 1) ? int'(shadow_last_row) : MAP_TILES - 1;
    sc = int'(c.start_col);
    sr = int'(c.start_row);
    rot = (shadow_rotation == ROT_UNUSED) ? ttcw_pkg::ROT_NONE : shadow_rotation;
    g = glyph_code(c.char_byte);
    nl = (g == int'(ttcw_pkg::NEWLINE_GLYPH));
    put = (g <= GLYPH_LIMIT);
    eol = 1'b0;

    // Load the start position for the rotation, clamped to the map
    if (c.sos) begin
      case (rot)
        ttcw_pkg::ROT_CW: begin
          cursor_col = (sr > lc) ? 0 : lc - sr;
          cursor_row = (sc > lr) ? lr : sc;
        end
        ttcw_pkg::ROT_CCW: begin
          cursor_col = (sr > lc) ? lc : sr;
          cursor_row = (sc > lr) ? 0 : lr - sc;
        end
        default: begin
          cursor_col = (sc > lc) ? lc : sc;
          cursor_row = (sr > lr) ? lr : sr;
        end
      endcase
    end
    if (cursor_col > lc) cursor_col = lc;
    if (cursor_row > lr) cursor_row = lr;

    w = '0;
    if (put) begin
      w.write_valid = 1'b1;
      w.col = cursor_col[5:0];
      w.row = cursor_row[5:0];
      w.value = {shadow_palette, 12'd0} | 16'(g);
      w.screen = c.screen;
      w.layer = c.layer;
    end

    // Advance with wrap along the line, then along the rows
    case (rot)
      ttcw_pkg::ROT_CW: begin
        if (put) begin
          cursor_row++;
          if (cursor_row > lr) eol = 1'b1;
        end
        if (eol || nl) begin
          cursor_row = 0;
          if (cursor_col == 0) cursor_col = lc;
          else cursor_col--;
        end
      end
      ttcw_pkg::ROT_CCW: begin
        if (put) begin
          if (cursor_row == 0) eol = 1'b1;
          else cursor_row--;
        end
        if (eol || nl) begin
          cursor_row = lr;
          cursor_col++;
          if (cursor_col > lc) cursor_col = 0;
        end
      end
      default: begin
        if (put) begin
          cursor_col++;
          if (cursor_col > lc) eol = 1'b1;
        end
        if (eol || nl) begin
          cursor_col = 0;
          cursor_row++;
          if (cursor_row > lr) cursor_row = 0;
        end
      end
    endcase
    cursor_col &= 127;
    cursor_row &= 127;
    return w;
  endfunction

  // Mostly short gaps, a few long ones, none when idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(32, 126));
    if (r < 65) return ttcw_pkg::NEWLINE_BYTE;
    if (r < 80) return LATIN1_ACCENTS[$urandom_range(0, 17)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic queue_char(logic [7:0] b, logic sos, logic [5:0] sc, logic [5:0] sr,
                            logic scr, logic [1:0] lay);
    char_item_t c;
    c.char_byte = b;
    c.sos = sos;
    c.start_col = sc;
    c.start_row = sr;
    c.screen = scr;
    c.layer = lay;
    char_pending_q.push_back(c);
  endtask

  // Strings with a start item and random text, mixed with stray items
  task automatic queue_random_text(int n_items);
    int n;
    int len;
    int k;
    logic scr;
    logic [1:0] lay;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        n++;
      end else begin
        len = $urandom_range(1, 14);
        scr = 1'($urandom_range(0, 1));
        lay = 2'($urandom_range(0, 3));
        for (k = 0; k < len && n < n_items; k++) begin
          queue_char(pick_text_byte(), k == 0, 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), scr, lay);
          n++;
        end
      end
    end
  endtask

  // Write all four registers, one per cycle, and mirror them
  task automatic apply_config(logic [1:0] rot, logic [5:0] lc, logic [5:0] lr,
                              logic [3:0] pal);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= ttcw_pkg::REG_ROTATION_MODE;
    cfg_data <= {4'd0, rot};
    @(posedge clk);
    cfg_index <= ttcw_pkg::REG_LAST_COLUMN;
    cfg_data <= lc;
    @(posedge clk);
    cfg_index <= ttcw_pkg::REG_LAST_ROW;
    cfg_data <= lr;
    @(posedge clk);
    cfg_index <= ttcw_pkg::REG_PALETTE_INDEX;
    cfg_data <= {2'd0, pal};
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_rotation = rot;
    shadow_last_col = lc;
    shadow_last_row = lr;
    shadow_palette = pal;
  endtask

  // Hold until every queued item is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (char_pending_q.size() != 0 || char_ch.valid || tile_expect_q.size() != 0);
    repeat (4) @(negedge clk);
    phase_count++;
  endtask

  function automatic logic [5:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 6'd0;
    if (r < 30) return 6'd63;
    if (r < 65) return 6'($urandom_range(1, 8));
    return 6'($urandom_range(0, 63));
  endfunction

  // Character driver: predict each accepted item, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      char_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        tile_expect_q.push_back(render_char(char_now));
        chars_sent++;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          char_ch.valid <= 1'b0;
        end else if (char_pending_q.size() > 0) begin
          char_now = char_pending_q.pop_front();
          char_ch.valid <= 1'b1;
          char_ch.char_byte <= char_now.char_byte;
          char_ch.start_of_string <= char_now.sos;
          char_ch.start_col <= char_now.start_col;
          char_ch.start_row <= char_now.start_row;
          char_ch.screen_sel <= char_now.screen;
          char_ch.layer_sel <= char_now.layer;
          send_gap = pick_gap();
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Tile monitor: check each accepted result, then stall at random
  always @(posedge clk) begin
    tile_write_t want;
    if (rst) begin
      tile_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (tile_ch.valid && tile_ch.ready) begin
        results_seen++;
        if (tile_expect_q.size() == 0) begin
          report_mismatch("result with nothing expected", tile_ch.tile_value, 16'd0);
        end else begin
          want = tile_expect_q.pop_front();
          if (want.write_valid) tiles_written++;
          else blank_results++;
          if (tile_ch.write_valid !== want.write_valid)
            report_mismatch("write_valid", 16'(tile_ch.write_valid), 16'(want.write_valid));
          if (tile_ch.tile_col !== want.col)
            report_mismatch("tile_col", 16'(tile_ch.tile_col), 16'(want.col));
          if (tile_ch.tile_row !== want.row)
            report_mismatch("tile_row", 16'(tile_ch.tile_row), 16'(want.row));
          if (tile_ch.tile_value !== want.value)
            report_mismatch("tile_value", tile_ch.tile_value, want.value);
          if (tile_ch.out_screen !== want.screen)
            report_mismatch("out_screen", 16'(tile_ch.out_screen), 16'(want.screen));
          if (tile_ch.out_layer !== want.layer)
            report_mismatch("out_layer", 16'(tile_ch.out_layer), 16'(want.layer));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        tile_ch.ready <= 1'b0;
      end else begin
        tile_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Stimulus sequence
  initial begin
    int p;
    logic [1:0] rot;
    char_ch.valid = 1'b0;
    char_ch.char_byte = '0;
    char_ch.start_of_string = 1'b0;
    char_ch.start_col = '0;
    char_ch.start_row = '0;
    char_ch.screen_sel = 1'b0;
    char_ch.layer_sel = '0;
    tile_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: glyph extremes, star, controls, newline, accents, start past the map
    queue_char("A", 1'b1, 6'd0, 6'd0, 1'b0, 2'd0);
    queue_char(8'd32, 1'b0, 6'd63, 6'd63, 1'b0, 2'd0);
    queue_char(8'd126, 1'b0, 6'd0, 6'd0, 1'b0, 2'd1);
    queue_char(8'd127, 1'b0, 6'd0, 6'd0, 1'b0, 2'd1);
    queue_char(ttcw_pkg::STAR_BYTE, 1'b0, 6'd0, 6'd0, 1'b1, 2'd2);
    queue_char(8'd0, 1'b0, 6'd0, 6'd0, 1'b1, 2'd2);
    queue_char(8'd31, 1'b0, 6'd0, 6'd0, 1'b0, 2'd3);
    queue_char(ttcw_pkg::NEWLINE_BYTE, 1'b0, 6'd0, 6'd0, 1'b1, 2'd3);
    queue_char(8'd128, 1'b0, 6'd0, 6'd0, 1'b0, 2'd0);
    queue_char(8'd255, 1'b0, 6'd0, 6'd0, 1'b0, 2'd0);
    queue_char(8'd199, 1'b0, 6'd0, 6'd0, 1'b0, 2'd0);
    queue_char(8'd191, 1'b0, 6'd0, 6'd0, 1'b0, 2'd0);
    queue_char(8'd161, 1'b0, 6'd0, 6'd0, 1'b1, 2'd3);
    queue_char("Z", 1'b1, 6'd63, 6'd63, 1'b1, 2'd2);
    queue_char("q", 1'b0, 6'd0, 6'd0, 1'b1, 2'd2);
    wait_drained();

    // Clockwise on a tiny map: rotated start below zero, wrap, newline
    apply_config(ttcw_pkg::ROT_CW, 6'd5, 6'd3, 4'd15);
    queue_char("B", 1'b1, 6'd40, 6'd40, 1'b0, 2'd1);
    queue_char(ttcw_pkg::NEWLINE_BYTE, 1'b0, 6'd0, 6'd0, 1'b0, 2'd1);
    queue_char("C", 1'b1, 6'd2, 6'd1, 1'b1, 2'd1);
    wait_drained();

    // Counter-clockwise on the full map: corner starts and column wrap
    apply_config(ttcw_pkg::ROT_CCW, 6'd63, 6'd63, 4'd9);
    queue_char("D", 1'b1, 6'd63, 6'd63, 1'b0, 2'd2);
    queue_char(8'd254, 1'b1, 6'd0, 6'd0, 1'b1, 2'd2);
    queue_char(ttcw_pkg::NEWLINE_BYTE, 1'b0, 6'd0, 6'd0, 1'b0, 2'd2);
    wait_drained();

    // Unused rotation code and a one-tile map: held cursor must clamp
    apply_config(ROT_UNUSED, 6'd0, 6'd0, 4'd1);
    queue_char("E", 1'b0, 6'd0, 6'd0, 1'b0, 2'd3);
    queue_char(ttcw_pkg::NEWLINE_BYTE, 1'b0, 6'd0, 6'd0, 1'b0, 2'd3);
    queue_char("F", 1'b1, 6'd63, 6'd0, 1'b1, 2'd3);
    wait_drained();

    // Random phases; every fourth one runs with no idling at all
    for (p = 0; p < 14; p++) begin
      idle_on = (p % 4 != 1);
      rot = ($urandom_range(0, 19) == 0) ? ROT_UNUSED : 2'($urandom_range(0, 2));
      apply_config(rot, pick_limit(), pick_limit(), 4'($urandom_range(0, 15)));
      queue_random_text(73);
      wait_drained();
    end

    if (tile_expect_q.size() != 0) begin
      report_mismatch("results never delivered", 16'(tile_expect_q.size()), 16'd0);
    end
    $display("Covered %0d characters over %0d setting phases, all rotations and map sizes.",
             chars_sent, phase_count);
    $display("Results checked: %0d tile writes and %0d blank results, %0d mismatches.",
             tiles_written, blank_results, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Give up if the block stops moving items
  initial begin
    #1500000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### text_tile_cursor_writer_top.f
+incdir+hdl
hdl/ttcw_pkg.sv
hdl/ttcw_if.sv
hdl/ttcw_cursor.sv
hdl/text_tile_cursor_writer_top.sv
tb/tb_top.sv
